/* src/qgf_pkg.sv */
// Shared widths, codes and the arithmetic sequence of the quaternion fusion block.
// Used by the interfaces, the normaliser and the top level; depends on nothing.
package qgf_pkg;

    localparam int GW    = 16;   // sensor, gain and time step fields
    localparam int QW    = 32;   // Q2.30 quaternion elements
    localparam int NW    = 60;   // normaliser input width
    localparam int NQW   = 39;   // quaternion after integration, before renormalising
    localparam int FW    = 34;   // objective terms
    localparam int OPW   = 35;   // multiplier operands
    localparam int PW    = 2 * OPW;
    localparam int ACCW  = PW;
    localparam int M40W  = 47;
    localparam int LOW   = 24;
    localparam int HIW   = M40W - LOW;
    localparam int PCW   = 6;

    localparam logic [GW-1:0]        GAIN_RESET = 16'd4954;
    localparam logic signed [QW-1:0] ONE_Q30    = 32'sh4000_0000;

    localparam logic [PCW-1:0] SEG1_LAST  = 6'd15;
    localparam logic [PCW-1:0] SEG2_FIRST = 6'd16;
    localparam logic [PCW-1:0] PROG_LAST  = 6'd39;

    typedef logic signed [NW-1:0] t_nin;
    typedef logic signed [QW-1:0] t_nout;

    typedef struct packed {
        logic done;
        logic ok;
    } t_norm_sts;

    typedef enum logic [4:0] {
        SRC_ZERO, SRC_W, SRC_X, SRC_Y, SRC_Z, SRC_F1, SRC_F2, SRC_F3,
        SRC_GX, SRC_GY, SRC_GZ, SRC_GN0, SRC_GN1, SRC_GN2, SRC_GN3,
        SRC_BETA, SRC_HI, SRC_LO, SRC_DT
    } t_src;

    typedef enum logic [1:0] {
        POST_RAW, POST_RND7, POST_RND8, POST_SHL24
    } t_post;

    typedef enum logic [3:0] {
        DST_NONE, DST_F1, DST_F2, DST_F3, DST_G0, DST_G1, DST_G2, DST_G3,
        DST_D, DST_ST0, DST_ST1, DST_ST2, DST_ST3
    } t_dst;

    typedef struct packed {
        t_src  a;
        t_src  b;
        logic  clr;
        logic  neg;
        t_post post;
        t_dst  dst;
    } t_uop;

    function automatic t_uop mk(t_src a, t_src b, logic clr, logic neg, t_post post,
                                t_dst dst);
        t_uop u;
        u.a    = a;
        u.b    = b;
        u.clr  = clr;
        u.neg  = neg;
        u.post = post;
        u.dst  = dst;
        return u;
    endfunction

    // Multiply-accumulate sequence: objective, gradient, then rate and step per element.
    function automatic t_uop uop(logic [PCW-1:0] pc);
        t_uop u;
        unique case (pc)
            6'd0:  u = mk(SRC_X, SRC_Z, 1'b1, 1'b0, POST_RAW, DST_NONE);
            6'd1:  u = mk(SRC_W, SRC_Y, 1'b0, 1'b1, POST_RAW, DST_F1);
            6'd2:  u = mk(SRC_W, SRC_X, 1'b1, 1'b0, POST_RAW, DST_NONE);
            6'd3:  u = mk(SRC_Y, SRC_Z, 1'b0, 1'b0, POST_RAW, DST_F2);
            6'd4:  u = mk(SRC_X, SRC_X, 1'b1, 1'b0, POST_RAW, DST_NONE);
            6'd5:  u = mk(SRC_Y, SRC_Y, 1'b0, 1'b0, POST_RAW, DST_F3);
            6'd6:  u = mk(SRC_X, SRC_F2, 1'b1, 1'b0, POST_RND8, DST_NONE);
            6'd7:  u = mk(SRC_Y, SRC_F1, 1'b0, 1'b1, POST_RND8, DST_G0);
            6'd8:  u = mk(SRC_Z, SRC_F1, 1'b1, 1'b0, POST_RND8, DST_NONE);
            6'd9:  u = mk(SRC_W, SRC_F2, 1'b0, 1'b0, POST_RND8, DST_NONE);
            6'd10: u = mk(SRC_X, SRC_F3, 1'b0, 1'b1, POST_RND7, DST_G1);
            6'd11: u = mk(SRC_Z, SRC_F2, 1'b1, 1'b0, POST_RND8, DST_NONE);
            6'd12: u = mk(SRC_Y, SRC_F3, 1'b0, 1'b1, POST_RND7, DST_NONE);
            6'd13: u = mk(SRC_W, SRC_F1, 1'b0, 1'b1, POST_RND8, DST_G2);
            6'd14: u = mk(SRC_X, SRC_F1, 1'b1, 1'b0, POST_RND8, DST_NONE);
            6'd15: u = mk(SRC_Y, SRC_F2, 1'b0, 1'b0, POST_RND8, DST_G3);
            6'd16: u = mk(SRC_X, SRC_GX, 1'b1, 1'b1, POST_RAW, DST_NONE);
            6'd17: u = mk(SRC_Y, SRC_GY, 1'b0, 1'b1, POST_RAW, DST_NONE);
            6'd18: u = mk(SRC_Z, SRC_GZ, 1'b0, 1'b1, POST_RAW, DST_NONE);
            6'd19: u = mk(SRC_BETA, SRC_GN0, 1'b0, 1'b1, POST_RAW, DST_D);
            6'd20: u = mk(SRC_HI, SRC_DT, 1'b1, 1'b0, POST_SHL24, DST_NONE);
            6'd21: u = mk(SRC_LO, SRC_DT, 1'b0, 1'b0, POST_RAW, DST_ST0);
            6'd22: u = mk(SRC_W, SRC_GX, 1'b1, 1'b0, POST_RAW, DST_NONE);
            6'd23: u = mk(SRC_Y, SRC_GZ, 1'b0, 1'b0, POST_RAW, DST_NONE);
            6'd24: u = mk(SRC_Z, SRC_GY, 1'b0, 1'b1, POST_RAW, DST_NONE);
            6'd25: u = mk(SRC_BETA, SRC_GN1, 1'b0, 1'b1, POST_RAW, DST_D);
            6'd26: u = mk(SRC_HI, SRC_DT, 1'b1, 1'b0, POST_SHL24, DST_NONE);
            6'd27: u = mk(SRC_LO, SRC_DT, 1'b0, 1'b0, POST_RAW, DST_ST1);
            6'd28: u = mk(SRC_W, SRC_GY, 1'b1, 1'b0, POST_RAW, DST_NONE);
            6'd29: u = mk(SRC_X, SRC_GZ, 1'b0, 1'b1, POST_RAW, DST_NONE);
            6'd30: u = mk(SRC_Z, SRC_GX, 1'b0, 1'b0, POST_RAW, DST_NONE);
            6'd31: u = mk(SRC_BETA, SRC_GN2, 1'b0, 1'b1, POST_RAW, DST_D);
            6'd32: u = mk(SRC_HI, SRC_DT, 1'b1, 1'b0, POST_SHL24, DST_NONE);
            6'd33: u = mk(SRC_LO, SRC_DT, 1'b0, 1'b0, POST_RAW, DST_ST2);
            6'd34: u = mk(SRC_W, SRC_GZ, 1'b1, 1'b0, POST_RAW, DST_NONE);
            6'd35: u = mk(SRC_X, SRC_GY, 1'b0, 1'b0, POST_RAW, DST_NONE);
            6'd36: u = mk(SRC_Y, SRC_GX, 1'b0, 1'b1, POST_RAW, DST_NONE);
            6'd37: u = mk(SRC_BETA, SRC_GN3, 1'b0, 1'b1, POST_RAW, DST_D);
            6'd38: u = mk(SRC_HI, SRC_DT, 1'b1, 1'b0, POST_SHL24, DST_NONE);
            6'd39: u = mk(SRC_LO, SRC_DT, 1'b0, 1'b0, POST_RAW, DST_ST3);
            default: u = mk(SRC_ZERO, SRC_ZERO, 1'b1, 1'b0, POST_RAW, DST_NONE);
        endcase
        return u;
    endfunction

endpackage

/* src/qgf_if.sv */
// Valid/ready channel interfaces for the sample input and the quaternion result.
// Depends on qgf_pkg for the field widths.
interface qgf_in_if;
    logic                           valid;
    logic                           ready;
    logic signed [qgf_pkg::GW-1:0]  gyro_x;
    logic signed [qgf_pkg::GW-1:0]  gyro_y;
    logic signed [qgf_pkg::GW-1:0]  gyro_z;
    logic signed [qgf_pkg::GW-1:0]  accel_x;
    logic signed [qgf_pkg::GW-1:0]  accel_y;
    logic signed [qgf_pkg::GW-1:0]  accel_z;
    logic        [qgf_pkg::GW-1:0]  time_step;

    modport source (output valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                    time_step, input ready);
    modport sink   (input valid, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                    time_step, output ready);
endinterface

interface qgf_out_if;
    logic                           valid;
    logic                           ready;
    logic signed [qgf_pkg::QW-1:0]  quat_w;
    logic signed [qgf_pkg::QW-1:0]  quat_x;
    logic signed [qgf_pkg::QW-1:0]  quat_y;
    logic signed [qgf_pkg::QW-1:0]  quat_z;
    logic                           no_correction;

    modport source (output valid, quat_w, quat_x, quat_y, quat_z, no_correction,
                    input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, no_correction,
                    output ready);
endinterface

/* src/qgf_norm.sv */
// Iterative four-element normaliser: common shift, sum of squares, bitwise square
// root and restoring division to Q2.30. Depends on qgf_pkg.
module qgf_norm (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  qgf_pkg::t_nin         i_v [4],
    output qgf_pkg::t_norm_sts    o_sts,
    output qgf_pkg::t_nout        o_q [4]
);

    localparam int NW = qgf_pkg::NW;
    localparam int QW = qgf_pkg::QW;

    typedef enum logic [2:0] {
        N_IDLE, N_MAG, N_SHIFT, N_SQ, N_SQRT, N_DIVI, N_DIV, N_DONE
    } t_nstate;

    t_nstate          r_state;
    logic [NW-1:0]    r_m [4];
    logic             r_neg [4];
    logic [NW-1:0]    r_top;
    logic [1:0]       r_k;
    logic [63:0]      r_sum;
    logic [63:0]      r_root;
    logic [4:0]       r_bitk;
    logic [31:0]      r_rem;
    logic [29:0]      r_quo;
    logic [4:0]       r_i;
    logic [1:0]       r_e;
    logic             r_ok;
    qgf_pkg::t_nout   r_q [4];

    logic [63:0]      bitv;
    logic [63:0]      trial;
    logic [59:0]      sq;
    logic [32:0]      rem2;
    logic [32:0]      divisor;
    logic             qbit;
    logic [30:0]      quo_fin;

    always_comb begin
        bitv    = 64'd1 << {r_bitk, 1'b0};
        trial   = r_root + bitv;
        sq      = r_m[r_k][29:0] * r_m[r_k][29:0];
        rem2    = {r_rem, (r_i == 5'd30) ? r_m[r_e][0] : 1'b0};
        divisor = {1'b0, r_root[31:0]};
        qbit    = (rem2 >= divisor);
        quo_fin = {r_quo, qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_ok    <= 1'b0;
        end else begin
            unique case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        for (int n = 0; n < 4; n++) begin
                            r_neg[n] <= i_v[n][NW-1];
                            r_m[n]   <= i_v[n][NW-1] ? NW'(-i_v[n]) : NW'(i_v[n]);
                        end
                        r_top   <= '0;
                        r_k     <= '0;
                        r_state <= N_MAG;
                    end
                end
                N_MAG: begin
                    if (r_m[r_k] > r_top) begin
                        r_top <= r_m[r_k];
                    end
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= N_SHIFT;
                    end
                end
                N_SHIFT: begin
                    if (r_top == '0) begin
                        r_ok    <= 1'b0;
                        r_state <= N_DONE;
                    end else if (r_top >= (NW'(1) << 30)) begin
                        for (int n = 0; n < 4; n++) begin
                            r_m[n] <= r_m[n] >> 1;
                        end
                        r_top <= r_top >> 1;
                    end else if (r_top < (NW'(1) << 29)) begin
                        for (int n = 0; n < 4; n++) begin
                            r_m[n] <= r_m[n] << 1;
                        end
                        r_top <= r_top << 1;
                    end else begin
                        r_sum   <= '0;
                        r_k     <= '0;
                        r_state <= N_SQ;
                    end
                end
                N_SQ: begin
                    r_sum <= r_sum + 64'(sq);
                    r_k   <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_root  <= '0;
                        r_bitk  <= 5'd31;
                        r_state <= N_SQRT;
                    end
                end
                N_SQRT: begin
                    if (r_sum >= trial) begin
                        r_sum  <= r_sum - trial;
                        r_root <= (r_root >> 1) + bitv;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    if (r_bitk == 5'd0) begin
                        r_e     <= '0;
                        r_state <= N_DIVI;
                    end else begin
                        r_bitk <= r_bitk - 5'd1;
                    end
                end
                N_DIVI: begin
                    // The upper dividend bits give zero quotient bits; start from m/2.
                    r_rem   <= 32'(r_m[r_e][29:1]);
                    r_quo   <= '0;
                    r_i     <= 5'd30;
                    r_state <= N_DIV;
                end
                N_DIV: begin
                    r_rem <= qbit ? 32'(rem2 - divisor) : rem2[31:0];
                    r_quo <= quo_fin[29:0];
                    if (r_i == 5'd0) begin
                        r_q[r_e] <= r_neg[r_e] ? -QW'(quo_fin) : QW'(quo_fin);
                        if (r_e == 2'd3) begin
                            r_ok    <= 1'b1;
                            r_state <= N_DONE;
                        end else begin
                            r_e     <= r_e + 2'd1;
                            r_state <= N_DIVI;
                        end
                    end else begin
                        r_i <= r_i - 5'd1;
                    end
                end
                N_DONE: begin
                    r_state <= N_IDLE;
                end
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_sts.done = (r_state == N_DONE);
    assign o_sts.ok   = r_ok;
    assign o_q        = r_q;

endmodule

/* src/imu_quaternion_gradient_fusion.sv */
// Top level of the gradient-descent IMU orientation filter: sequencer, shared
// multiply-accumulate unit and orientation state. Depends on qgf_pkg, qgf_if, qgf_norm.
//
//  channel   | direction | transaction
//  i_in      | sink      | gyro x/y/z, accel x/y/z, time_step
//  o_res     | source    | quat w/x/y/z, no_correction
//  i_cfg_*   | write     | correction_gain, taken whenever i_cfg_we is high
//
// One sample takes up to three passes of the normaliser (each scaling shifts, a 32-step
// square root and four divisions, or an early exit for an all-zero vector) plus 24 or 40
// multiply-accumulate steps on the shared multiplier.
// Reset loads the identity orientation and the default gain. A result waiting on
// o_res does not block a new sample; only the next result waits for it to be taken.
module imu_quaternion_gradient_fusion (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    qgf_in_if.sink                   i_in,
    qgf_out_if.source                o_res,
    input  logic                     i_cfg_we,
    input  logic [qgf_pkg::GW-1:0]   i_cfg_data
);

    localparam int GW   = qgf_pkg::GW;
    localparam int QW   = qgf_pkg::QW;
    localparam int NW   = qgf_pkg::NW;
    localparam int NQW  = qgf_pkg::NQW;
    localparam int FW   = qgf_pkg::FW;
    localparam int OPW  = qgf_pkg::OPW;
    localparam int PW   = qgf_pkg::PW;
    localparam int ACCW = qgf_pkg::ACCW;
    localparam int M40W = qgf_pkg::M40W;
    localparam int LOW  = qgf_pkg::LOW;
    localparam int HIW  = qgf_pkg::HIW;
    localparam int PCW  = qgf_pkg::PCW;

    typedef enum logic [3:0] {
        S_IDLE, S_NA, S_NA_W, S_MUL, S_ACC, S_NG, S_NG_W, S_NQ, S_NQ_W, S_FIN
    } t_state;

    t_state                   r_state;
    logic [GW-1:0]            r_gain;
    logic signed [QW-1:0]     r_q [4];
    logic signed [GW-1:0]     r_gx, r_gy, r_gz, r_ax, r_ay, r_az;
    logic [GW-1:0]            r_dt;
    logic signed [QW-1:0]     r_an [3];
    logic signed [FW-1:0]     r_f1, r_f2, r_f3;
    logic signed [NW-1:0]     r_g [4];
    logic signed [QW-1:0]     r_gn [4];
    logic                     r_skip;
    logic                     r_dneg;
    logic [HIW-1:0]           r_hi;
    logic [LOW-1:0]           r_lo;
    logic signed [NQW-1:0]    r_nq [4];
    logic signed [PW-1:0]     r_p;
    logic signed [ACCW-1:0]   r_acc;
    logic [PCW-1:0]           r_pc;
    logic                     r_ovalid;
    logic signed [QW-1:0]     r_ow, r_ox, r_oy, r_oz;
    logic                     r_onc;

    qgf_pkg::t_uop            cur;
    qgf_pkg::t_nin            nv [4];
    qgf_pkg::t_nout           nq_out [4];
    qgf_pkg::t_norm_sts       nsts;
    logic                     nstart;

    logic signed [OPW-1:0]    op_a, op_b;
    logic signed [PW-1:0]     p_mag, p_r7, p_r8, term_u, term;
    logic signed [ACCW-1:0]   acc_next, acc_mag, r29, r29_s, st_full;
    logic [ACCW-1:0]          m40_full;
    logic signed [NQW-1:0]    st;

    function automatic logic signed [OPW-1:0] src_val(qgf_pkg::t_src s);
        logic signed [OPW-1:0] v;
        case (s)
            qgf_pkg::SRC_W:    v = OPW'(r_q[0]);
            qgf_pkg::SRC_X:    v = OPW'(r_q[1]);
            qgf_pkg::SRC_Y:    v = OPW'(r_q[2]);
            qgf_pkg::SRC_Z:    v = OPW'(r_q[3]);
            qgf_pkg::SRC_F1:   v = OPW'(r_f1);
            qgf_pkg::SRC_F2:   v = OPW'(r_f2);
            qgf_pkg::SRC_F3:   v = OPW'(r_f3);
            qgf_pkg::SRC_GX:   v = OPW'(r_gx) <<< 5;
            qgf_pkg::SRC_GY:   v = OPW'(r_gy) <<< 5;
            qgf_pkg::SRC_GZ:   v = OPW'(r_gz) <<< 5;
            qgf_pkg::SRC_GN0:  v = r_skip ? '0 : OPW'(r_gn[0]);
            qgf_pkg::SRC_GN1:  v = r_skip ? '0 : OPW'(r_gn[1]);
            qgf_pkg::SRC_GN2:  v = r_skip ? '0 : OPW'(r_gn[2]);
            qgf_pkg::SRC_GN3:  v = r_skip ? '0 : OPW'(r_gn[3]);
            qgf_pkg::SRC_BETA: v = OPW'($signed({1'b0, r_gain}));
            qgf_pkg::SRC_HI:   v = OPW'($signed({1'b0, r_hi}));
            qgf_pkg::SRC_LO:   v = OPW'($signed({1'b0, r_lo}));
            qgf_pkg::SRC_DT:   v = OPW'($signed({1'b0, r_dt}));
            default:           v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        cur   = qgf_pkg::uop(r_pc);
        op_a  = src_val(cur.a);
        op_b  = src_val(cur.b);

        p_mag = r_p[PW-1] ? -r_p : r_p;
        p_r7  = (p_mag + PW'(64)) >>> 7;
        p_r8  = (p_mag + PW'(128)) >>> 8;
        case (cur.post)
            qgf_pkg::POST_RND7:  term_u = r_p[PW-1] ? -p_r7 : p_r7;
            qgf_pkg::POST_RND8:  term_u = r_p[PW-1] ? -p_r8 : p_r8;
            qgf_pkg::POST_SHL24: term_u = r_p <<< 24;
            default:             term_u = r_p;
        endcase
        term     = cur.neg ? -term_u : term_u;
        acc_next = cur.clr ? ACCW'(term) : r_acc + ACCW'(term);

        acc_mag  = acc_next[ACCW-1] ? -acc_next : acc_next;
        r29      = (acc_mag + (ACCW'(1) <<< 28)) >>> 29;
        r29_s    = acc_next[ACCW-1] ? -r29 : r29;
        m40_full = ACCW'((acc_mag + ACCW'(32)) >>> 6);
        // The step accumulator is never negative; the sign of d is applied afterwards.
        st_full  = (acc_next + (ACCW'(1) <<< 25)) >>> 26;
        st       = NQW'(st_full);
    end

    always_comb begin
        nstart = (r_state == S_NA) || (r_state == S_NG) || (r_state == S_NQ);
        if ((r_state == S_NA) || (r_state == S_NA_W)) begin
            nv[0] = NW'(r_ax);
            nv[1] = NW'(r_ay);
            nv[2] = NW'(r_az);
            nv[3] = '0;
        end else if ((r_state == S_NG) || (r_state == S_NG_W)) begin
            nv = r_g;
        end else begin
            for (int n = 0; n < 4; n++) begin
                nv[n] = NW'(r_nq[n]);
            end
        end
    end

    qgf_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (nstart),
        .i_v     (nv),
        .o_sts   (nsts),
        .o_q     (nq_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gain   <= qgf_pkg::GAIN_RESET;
            r_q[0]   <= qgf_pkg::ONE_Q30;
            r_q[1]   <= '0;
            r_q[2]   <= '0;
            r_q[3]   <= '0;
            r_ovalid <= 1'b0;
            r_pc     <= '0;
            r_skip   <= 1'b1;
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_data;
            end
            if (r_ovalid && o_res.ready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_gx    <= i_in.gyro_x;
                        r_gy    <= i_in.gyro_y;
                        r_gz    <= i_in.gyro_z;
                        r_ax    <= i_in.accel_x;
                        r_ay    <= i_in.accel_y;
                        r_az    <= i_in.accel_z;
                        r_dt    <= i_in.time_step;
                        r_skip  <= 1'b1;
                        r_state <= S_NA;
                    end
                end
                S_NA: r_state <= S_NA_W;
                S_NA_W: begin
                    if (nsts.done) begin
                        if (nsts.ok) begin
                            for (int n = 0; n < 3; n++) begin
                                r_an[n] <= nq_out[n];
                            end
                            r_pc <= '0;
                        end else begin
                            r_pc <= qgf_pkg::SEG2_FIRST;
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p     <= PW'(op_a) * PW'(op_b);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= acc_next;
                    case (cur.dst)
                        qgf_pkg::DST_F1: r_f1 <= FW'(r29_s) - FW'(r_an[0]);
                        qgf_pkg::DST_F2: r_f2 <= FW'(r29_s) - FW'(r_an[1]);
                        qgf_pkg::DST_F3: r_f3 <= FW'(qgf_pkg::ONE_Q30) - FW'(r29_s)
                                                 - FW'(r_an[2]);
                        qgf_pkg::DST_G0: r_g[0] <= NW'(acc_next);
                        qgf_pkg::DST_G1: r_g[1] <= NW'(acc_next);
                        qgf_pkg::DST_G2: r_g[2] <= NW'(acc_next);
                        qgf_pkg::DST_G3: r_g[3] <= NW'(acc_next);
                        qgf_pkg::DST_D: begin
                            r_dneg <= acc_next[ACCW-1];
                            r_hi   <= m40_full[M40W-1:LOW];
                            r_lo   <= m40_full[LOW-1:0];
                        end
                        qgf_pkg::DST_ST0: r_nq[0] <= NQW'(r_q[0]) + (r_dneg ? -st : st);
                        qgf_pkg::DST_ST1: r_nq[1] <= NQW'(r_q[1]) + (r_dneg ? -st : st);
                        qgf_pkg::DST_ST2: r_nq[2] <= NQW'(r_q[2]) + (r_dneg ? -st : st);
                        qgf_pkg::DST_ST3: r_nq[3] <= NQW'(r_q[3]) + (r_dneg ? -st : st);
                        default: ;
                    endcase
                    if (r_pc == qgf_pkg::SEG1_LAST) begin
                        r_state <= S_NG;
                    end else if (r_pc == qgf_pkg::PROG_LAST) begin
                        r_state <= S_NQ;
                    end else begin
                        r_pc    <= r_pc + PCW'(1);
                        r_state <= S_MUL;
                    end
                end
                S_NG: r_state <= S_NG_W;
                S_NG_W: begin
                    if (nsts.done) begin
                        if (nsts.ok) begin
                            r_gn   <= nq_out;
                            r_skip <= 1'b0;
                        end
                        r_pc    <= qgf_pkg::SEG2_FIRST;
                        r_state <= S_MUL;
                    end
                end
                S_NQ: r_state <= S_NQ_W;
                S_NQ_W: begin
                    if (nsts.done) begin
                        // An all-zero quaternion keeps the stored orientation.
                        if (nsts.ok) begin
                            r_q <= nq_out;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || o_res.ready) begin
                        r_ow     <= r_q[0];
                        r_ox     <= r_q[1];
                        r_oy     <= r_q[2];
                        r_oz     <= r_q[3];
                        r_onc    <= r_skip;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_res.valid         = r_ovalid;
    assign o_res.quat_w        = r_ow;
    assign o_res.quat_x        = r_ox;
    assign o_res.quat_y        = r_oy;
    assign o_res.quat_z        = r_oz;
    assign o_res.no_correction = r_onc;

endmodule
